// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the road store.
// No dependencies; included by the modules that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define GRRS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// condition must never be seen outside reset
`define GRRS_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== sv/grrs_pkg.sv =====
// Package for the road store: field widths, defaults, operation codes, FSM states.
// No dependencies.
package grrs_pkg;

   localparam int MAX_CITIES_DEF  = 16;
   localparam int LENGTH_BITS_DEF = 16;

   localparam int FUNC_BITS       = 2;
   localparam int CITY_BITS       = 4;
   localparam int ROAD_LEN_BITS   = 16;
   localparam int NODE_COUNT_BITS = 5;

   localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RESET = 5'd16;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ADD     = 2'd0,
      FUNC_REMOVE  = 2'd1,
      FUNC_PATH    = 2'd2,
      FUNC_CONNECT = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_WR_AB,
      ST_WR_BA,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

// ===== sv/graph_road_store_reachability_top.sv =====
// Road store with path and connectivity queries over a symmetric length matrix.
// Depends on grrs_pkg and assert_macros.svh.
//
// One request at a time; req_ready is high only while the block is idle. An add goes
// through states ST_WR_AB and ST_WR_BA, a remove through ST_RD first, to the result
// register. Path and connectivity queries walk the road-presence rows one row per
// cycle through a single OR/compare unit: each round scans all MAX_CITIES rows and the
// walk ends after the first round that reaches no new city. A path query with the same
// city twice, and a connectivity query with node_count of 0 or 1, answer true without a
// walk. The length memory needs no clearing pass after reset: presence bits, cleared by
// reset, gate it. The result waits in an output register until rsp_ready takes it.
module graph_road_store_reachability_top #(
   parameter int MAX_CITIES  = grrs_pkg::MAX_CITIES_DEF,
   parameter int LENGTH_BITS = grrs_pkg::LENGTH_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [grrs_pkg::FUNC_BITS-1:0]       req_func,
   input  logic [grrs_pkg::CITY_BITS-1:0]       req_city_a,
   input  logic [grrs_pkg::CITY_BITS-1:0]       req_city_b,
   input  logic [grrs_pkg::ROAD_LEN_BITS-1:0]   req_road_length,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [grrs_pkg::ROAD_LEN_BITS-1:0]   rsp_removed_length,
   output logic                                 rsp_answer,
   input  logic                                 csr_wr_en,
   input  logic [grrs_pkg::NODE_COUNT_BITS-1:0] csr_wr_data
);

`include "assert_macros.svh"

   localparam int CW    = $clog2(MAX_CITIES);
   localparam int AW    = 2 * CW;
   localparam int DEPTH = 1 << AW;
   localparam logic [CW-1:0] LAST_CITY = CW'(MAX_CITIES - 1);

   // state
   grrs_pkg::state_type state_ff, state_in;

   logic [grrs_pkg::NODE_COUNT_BITS-1:0] node_count_ff;
   logic [MAX_CITIES-1:0]                rows_ff [MAX_CITIES];
   logic [LENGTH_BITS-1:0]               len_mem [DEPTH];

   logic [CW-1:0]          city_a_ff, city_a_in;
   logic [CW-1:0]          city_b_ff, city_b_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   is_path_ff, is_path_in;
   logic [MAX_CITIES-1:0]  seen_ff, seen_in;
   logic [MAX_CITIES-1:0]  allowed_ff, allowed_in;
   logic                   hit_ff, hit_in;
   logic                   changed_ff, changed_in;
   logic [CW-1:0]          x_ff, x_in;
   logic                   present_ff, present_in;
   logic [LENGTH_BITS-1:0] rd_data_ff;

   logic [grrs_pkg::ROAD_LEN_BITS-1:0] res_len_ff, res_len_in;
   logic                               res_ans_ff, res_ans_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [grrs_pkg::ROAD_LEN_BITS-1:0] rsp_len_ff, rsp_len_in;
   logic                               rsp_ans_ff, rsp_ans_in;

   // memory and row write controls
   logic          mem_we, mem_rd;
   logic [AW-1:0] mem_addr;
   logic          row_we, row_val;
   logic [CW-1:0] row_idx, row_bit;

   // walk datapath
   logic [CW-1:0]         rd_idx;
   logic [MAX_CITIES-1:0] row_rd;
   logic [MAX_CITIES-1:0] mask_now;
   logic [MAX_CITIES-1:0] add_bits;
   logic [CW-1:0]         req_a_idx, req_b_idx;
   logic                  req_in_range;

   assign req_ready          = (state_ff == grrs_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_removed_length = rsp_len_ff;
   assign rsp_answer         = rsp_ans_ff;

   assign req_a_idx    = CW'(req_city_a);
   assign req_b_idx    = CW'(req_city_b);
   assign req_in_range = (32'(req_city_a) < MAX_CITIES) && (32'(req_city_b) < MAX_CITIES);

   assign rd_idx = (state_ff == grrs_pkg::ST_WALK) ? x_ff : city_a_ff;
   assign row_rd = rows_ff[rd_idx];

   // cities allowed as walk intermediates: below node_count, saturated by the width
   always_comb begin
      for (int j = 0; j < MAX_CITIES; j++) begin
         mask_now[j] = (j < int'(node_count_ff));
      end
   end

   always_comb begin
      state_in     = state_ff;
      city_a_in    = city_a_ff;
      city_b_in    = city_b_ff;
      len_in       = len_ff;
      is_path_in   = is_path_ff;
      seen_in      = seen_ff;
      allowed_in   = allowed_ff;
      hit_in       = hit_ff;
      changed_in   = changed_ff;
      x_in         = x_ff;
      present_in   = present_ff;
      res_len_in   = res_len_ff;
      res_ans_in   = res_ans_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_len_in   = rsp_len_ff;
      rsp_ans_in   = rsp_ans_ff;
      mem_we       = 1'b0;
      mem_rd       = 1'b0;
      mem_addr     = {city_a_ff, city_b_ff};
      row_we       = 1'b0;
      row_idx      = city_a_ff;
      row_bit      = city_b_ff;
      row_val      = (len_ff != '0);
      add_bits     = row_rd & allowed_ff;

      case (state_ff)
         grrs_pkg::ST_IDLE: begin
            if (req_valid) begin
               city_a_in  = req_a_idx;
               city_b_in  = req_b_idx;
               len_in     = LENGTH_BITS'(req_road_length);
               present_in = 1'b0;
               res_len_in = '0;
               res_ans_in = 1'b0;
               allowed_in = mask_now;
               x_in       = '0;
               changed_in = 1'b0;
               hit_in     = 1'b0;
               case (grrs_pkg::func_type'(req_func))
                  grrs_pkg::FUNC_CONNECT: begin
                     city_b_in  = '0;
                     is_path_in = 1'b0;
                     if (node_count_ff <= grrs_pkg::NODE_COUNT_BITS'(1)) begin
                        res_ans_in = 1'b1;
                        state_in   = grrs_pkg::ST_DONE;
                     end else begin
                        seen_in  = MAX_CITIES'(1);
                        state_in = grrs_pkg::ST_WALK;
                     end
                  end
                  grrs_pkg::FUNC_ADD: begin
                     state_in = req_in_range ? grrs_pkg::ST_WR_AB : grrs_pkg::ST_DONE;
                  end
                  grrs_pkg::FUNC_REMOVE: begin
                     len_in   = '0;
                     state_in = req_in_range ? grrs_pkg::ST_RD : grrs_pkg::ST_DONE;
                  end
                  default: begin
                     is_path_in = 1'b1;
                     if (!req_in_range) begin
                        state_in = grrs_pkg::ST_DONE;
                     end else if (req_city_a == req_city_b) begin
                        res_ans_in = 1'b1;
                        state_in   = grrs_pkg::ST_DONE;
                     end else begin
                        seen_in  = MAX_CITIES'(1) << req_a_idx;
                        state_in = grrs_pkg::ST_WALK;
                     end
                  end
               endcase
            end
         end
         grrs_pkg::ST_RD: begin
            mem_rd     = 1'b1;
            present_in = row_rd[city_b_ff];
            state_in   = grrs_pkg::ST_WR_AB;
         end
         grrs_pkg::ST_WR_AB: begin
            mem_we   = 1'b1;
            row_we   = 1'b1;
            state_in = grrs_pkg::ST_WR_BA;
         end
         grrs_pkg::ST_WR_BA: begin
            mem_we   = 1'b1;
            mem_addr = {city_b_ff, city_a_ff};
            row_we   = 1'b1;
            row_idx  = city_b_ff;
            row_bit  = city_a_ff;
            // presence gates the memory, so never-written entries read as zero
            res_len_in = present_ff ? grrs_pkg::ROAD_LEN_BITS'(rd_data_ff) : '0;
            state_in   = grrs_pkg::ST_DONE;
         end
         grrs_pkg::ST_WALK: begin
            if (seen_ff[x_ff]) begin
               seen_in    = seen_ff | add_bits;
               changed_in = changed_ff | ((add_bits & ~seen_ff) != '0);
               hit_in     = hit_ff | row_rd[city_b_ff];
            end
            x_in = x_ff + CW'(1);
            if (x_ff == LAST_CITY) begin
               x_in = '0;
               if (changed_in) begin
                  changed_in = 1'b0;
                  hit_in     = 1'b0;
               end else begin
                  // round with no growth: seen is closed and hit covers every seen row
                  res_ans_in = is_path_ff ? (seen_in[city_b_ff] | hit_in)
                                          : ((seen_in & allowed_ff) == allowed_ff);
                  state_in   = grrs_pkg::ST_DONE;
               end
            end
         end
         grrs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = res_len_ff;
               rsp_ans_in   = res_ans_ff;
               state_in     = grrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = grrs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= grrs_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= grrs_pkg::NODE_COUNT_RESET;
         rows_ff       <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (row_we) begin
            rows_ff[row_idx][row_bit] <= row_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      city_a_ff  <= city_a_in;
      city_b_ff  <= city_b_in;
      len_ff     <= len_in;
      is_path_ff <= is_path_in;
      seen_ff    <= seen_in;
      allowed_ff <= allowed_in;
      hit_ff     <= hit_in;
      changed_ff <= changed_in;
      x_ff       <= x_in;
      present_ff <= present_in;
      res_len_ff <= res_len_in;
      res_ans_ff <= res_ans_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ans_ff <= rsp_ans_in;
   end

   // length memory: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         len_mem[mem_addr] <= len_ff;
      end
      if (mem_rd) begin
         rd_data_ff <= len_mem[mem_addr];
      end
   end

   // check terms
   logic req_fire, rows_sym, in_walk, in_done, seen_kept, rsp_rise;

   assign req_fire  = req_valid && req_ready && req_in_range;
   assign rows_sym  = (rows_ff[req_a_idx][req_b_idx] == rows_ff[req_b_idx][req_a_idx]);
   assign in_walk   = (state_ff == grrs_pkg::ST_WALK);
   assign in_done   = (state_ff == grrs_pkg::ST_DONE);
   assign seen_kept = ((seen_in & seen_ff) == seen_ff);
   assign rsp_rise  = rsp_valid_in && !rsp_valid_ff;

   `GRRS_ASSERT(a_rows_symmetric, clock, reset, req_fire |-> rows_sym, "rows not symmetric")
   `GRRS_ASSERT(a_seen_grows, clock, reset, in_walk |-> seen_kept, "walk dropped a reached city")
   `GRRS_ASSERT_NEVER(a_seen_nonempty, clock, reset, in_walk && (seen_ff == '0), "walk set empty")
   `GRRS_ASSERT(a_rsp_from_done, clock, reset, rsp_rise |-> in_done, "response not from done")

endmodule
